// ===== rtl/cbbc_pkg.sv =====
// Shared types, codes and helper functions for the bracket balance checker.
package cbbc_pkg;

  localparam int STACK_DEPTH_DEFAULT = 256;

  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_LSQUARE   = 8'h5b;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_LCURLY    = 8'h7b;
  localparam logic [7:0] CH_RSQUARE   = 8'h5d;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_RCURLY    = 8'h7d;

  typedef enum logic [8:0] {
    LX_NORMAL = 9'b000000001,
    LX_SQUOTE = 9'b000000010,
    LX_DQUOTE = 9'b000000100,
    LX_SQ_ESC = 9'b000001000,
    LX_DQ_ESC = 9'b000010000,
    LX_LINE   = 9'b000100000,
    LX_BLOCK  = 9'b001000000,
    LX_SLASH  = 9'b010000000,
    LX_STAR   = 9'b100000000
  } lex_t;

  typedef enum logic [3:0] {
    LC_NORMAL = 4'd0,
    LC_SQUOTE = 4'd1,
    LC_DQUOTE = 4'd2,
    LC_SQ_ESC = 4'd3,
    LC_DQ_ESC = 4'd4,
    LC_LINE   = 4'd5,
    LC_BLOCK  = 4'd6,
    LC_SLASH  = 4'd7,
    LC_STAR   = 4'd8
  } lex_code_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNEXP    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BALANCED = 3'd3,
    ST_UNBAL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNEXP    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    BR_PAREN  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2,
    BR_NONE   = 2'd3
  } brk_t;

  function automatic lex_code_t lex_code(lex_t s);
    lex_code_t c;
    unique case (s)
      LX_SQUOTE: c = LC_SQUOTE;
      LX_DQUOTE: c = LC_DQUOTE;
      LX_SQ_ESC: c = LC_SQ_ESC;
      LX_DQ_ESC: c = LC_DQ_ESC;
      LX_LINE:   c = LC_LINE;
      LX_BLOCK:  c = LC_BLOCK;
      LX_SLASH:  c = LC_SLASH;
      LX_STAR:   c = LC_STAR;
      default:   c = LC_NORMAL;
    endcase
    return c;
  endfunction

  function automatic brk_t open_code(logic [7:0] c);
    brk_t b;
    unique case (c)
      CH_LPAREN:  b = BR_PAREN;
      CH_LSQUARE: b = BR_SQUARE;
      CH_LCURLY:  b = BR_CURLY;
      default:    b = BR_NONE;
    endcase
    return b;
  endfunction

  function automatic brk_t close_code(logic [7:0] c);
    brk_t b;
    unique case (c)
      CH_RPAREN:  b = BR_PAREN;
      CH_RSQUARE: b = BR_SQUARE;
      CH_RCURLY:  b = BR_CURLY;
      default:    b = BR_NONE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] open_char(brk_t b);
    logic [7:0] c;
    unique case (b)
      BR_SQUARE: c = CH_LSQUARE;
      BR_CURLY:  c = CH_LCURLY;
      default:   c = CH_LPAREN;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/cbbc_lexer.sv =====
// Next-state logic of the C quote and comment lexer.
module cbbc_lexer (
  input  cbbc_pkg::lex_t cur,
  input  logic [7:0]     char_code,
  output cbbc_pkg::lex_t nxt
);

  cbbc_pkg::lex_t from_normal;

  always_comb begin
    priority if (char_code == cbbc_pkg::CH_SQUOTE) begin
      from_normal = cbbc_pkg::LX_SQUOTE;
    end else if (char_code == cbbc_pkg::CH_DQUOTE) begin
      from_normal = cbbc_pkg::LX_DQUOTE;
    end else if (char_code == cbbc_pkg::CH_SLASH) begin
      from_normal = cbbc_pkg::LX_SLASH;
    end else begin
      from_normal = cbbc_pkg::LX_NORMAL;
    end
  end

  always_comb begin
    unique case (cur)
      cbbc_pkg::LX_SQUOTE: begin
        priority if (char_code == cbbc_pkg::CH_SQUOTE) nxt = cbbc_pkg::LX_NORMAL;
        else if (char_code == cbbc_pkg::CH_BACKSLASH) nxt = cbbc_pkg::LX_SQ_ESC;
        else nxt = cbbc_pkg::LX_SQUOTE;
      end
      cbbc_pkg::LX_DQUOTE: begin
        priority if (char_code == cbbc_pkg::CH_DQUOTE) nxt = cbbc_pkg::LX_NORMAL;
        else if (char_code == cbbc_pkg::CH_BACKSLASH) nxt = cbbc_pkg::LX_DQ_ESC;
        else nxt = cbbc_pkg::LX_DQUOTE;
      end
      cbbc_pkg::LX_SQ_ESC: nxt = cbbc_pkg::LX_SQUOTE;
      cbbc_pkg::LX_DQ_ESC: nxt = cbbc_pkg::LX_DQUOTE;
      cbbc_pkg::LX_LINE: begin
        nxt = (char_code == cbbc_pkg::CH_NEWLINE) ? cbbc_pkg::LX_NORMAL
                                                  : cbbc_pkg::LX_LINE;
      end
      cbbc_pkg::LX_BLOCK: begin
        nxt = (char_code == cbbc_pkg::CH_STAR) ? cbbc_pkg::LX_STAR
                                               : cbbc_pkg::LX_BLOCK;
      end
      cbbc_pkg::LX_SLASH: begin
        priority if (char_code == cbbc_pkg::CH_STAR) nxt = cbbc_pkg::LX_BLOCK;
        else if (char_code == cbbc_pkg::CH_SLASH) nxt = cbbc_pkg::LX_LINE;
        else nxt = from_normal;
      end
      cbbc_pkg::LX_STAR: begin
        priority if (char_code == cbbc_pkg::CH_SLASH) nxt = cbbc_pkg::LX_NORMAL;
        else if (char_code == cbbc_pkg::CH_STAR) nxt = cbbc_pkg::LX_STAR;
        else nxt = cbbc_pkg::LX_BLOCK;
      end
      default: nxt = from_normal;
    endcase
  end

endmodule

// ===== rtl/cbbc_stack_mem.sv =====
// Bracket stack storage: one write port, one registered read port.
module cbbc_stack_mem #(
  parameter int DEPTH = cbbc_pkg::STACK_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  cbbc_pkg::brk_t      wr_data,
  input  logic [AW-1:0]       rd_addr,
  output cbbc_pkg::brk_t      rd_data
);

  cbbc_pkg::brk_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/c_bracket_balance_checker.sv =====
// Top level of the C bracket balance checker: lexer, stack control, result register.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  char_code, end_of_input
//   out      source     out_valid/out_stall  status, reported_char, nesting_depth,
//                                            lexer_state
//
// One transfer per cycle in and out while in_stall is low; each byte's result is registered
// and presented in the cycle after the byte is accepted. The stack memory is read every
// cycle at the entry below the new top, so a pop has the next top ready for the following byte.
// Synchronous reset clears the lexer, count, top, bottom, error, error char and output valid; memory is not cleared.
// in_stall is raised only while a result is held and out_stall is high.
module c_bracket_balance_checker #(
  parameter int STACK_DEPTH = cbbc_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] reported_char,
  output logic [8:0] nesting_depth,
  output logic [3:0] lexer_state
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  cbbc_pkg::lex_t  lex, lex_next, lex_step;
  logic [CW-1:0]   count, count_next;
  cbbc_pkg::brk_t  top, top_next;
  cbbc_pkg::brk_t  bottom, bottom_next;
  cbbc_pkg::err_t  err, err_next;
  logic [7:0]      err_char, err_char_next;
  cbbc_pkg::brk_t  second;
  cbbc_pkg::brk_t  oc, cc;
  logic            accept;
  logic            push;
  logic [CW-1:0]   rd_cnt;
  cbbc_pkg::status_t res_status;
  logic [7:0]      res_char;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  cbbc_lexer u_lexer (
    .cur       (lex),
    .char_code (char_code),
    .nxt       (lex_step)
  );

  assign oc = cbbc_pkg::open_code(char_code);
  assign cc = cbbc_pkg::close_code(char_code);

  always_comb begin
    lex_next      = lex;
    count_next    = count;
    top_next      = top;
    bottom_next   = bottom;
    err_next      = err;
    err_char_next = err_char;
    push          = 1'b0;
    res_status    = cbbc_pkg::ST_OK;
    res_char      = 8'd0;
    if (accept) begin
      priority if (end_of_input) begin
        priority if (err != cbbc_pkg::ERR_NONE) begin
          res_status = cbbc_pkg::status_t'({1'b0, err});
          res_char   = err_char;
        end else if (count == '0) begin
          res_status = cbbc_pkg::ST_BALANCED;
        end else begin
          res_status = cbbc_pkg::ST_UNBAL;
          res_char   = cbbc_pkg::open_char(bottom);
        end
        lex_next      = cbbc_pkg::LX_NORMAL;
        count_next    = '0;
        top_next      = cbbc_pkg::BR_PAREN;
        bottom_next   = cbbc_pkg::BR_PAREN;
        err_next      = cbbc_pkg::ERR_NONE;
        err_char_next = 8'd0;
      end else if (err != cbbc_pkg::ERR_NONE) begin
        res_status = cbbc_pkg::status_t'({1'b0, err});
        res_char   = err_char;
      end else begin
        lex_next = lex_step;
        if (lex_step == cbbc_pkg::LX_NORMAL) begin
          priority if (oc != cbbc_pkg::BR_NONE) begin
            if (count >= FULL) begin
              err_next      = cbbc_pkg::ERR_OVERFLOW;
              err_char_next = char_code;
            end else begin
              push       = 1'b1;
              count_next = count + CW'(1);
              top_next   = oc;
              if (count == '0) begin
                bottom_next = oc;
              end
            end
          end else if (cc != cbbc_pkg::BR_NONE) begin
            if (count == '0 || top != cc) begin
              err_next      = cbbc_pkg::ERR_UNEXP;
              err_char_next = char_code;
            end else begin
              count_next = count - CW'(1);
              top_next   = (count > CW'(1)) ? second : cbbc_pkg::BR_PAREN;
            end
          end else begin
            top_next = top;
          end
        end
        if (err_next != cbbc_pkg::ERR_NONE) begin
          res_status = cbbc_pkg::status_t'({1'b0, err_next});
          res_char   = err_char_next;
        end
      end
    end
  end

  assign rd_cnt = count_next - CW'(2);

  cbbc_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (count[AW-1:0]),
    .wr_data (oc),
    .rd_addr (rd_cnt[AW-1:0]),
    .rd_data (second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lex       <= cbbc_pkg::LX_NORMAL;
      count     <= '0;
      top       <= cbbc_pkg::BR_PAREN;
      bottom    <= cbbc_pkg::BR_PAREN;
      err       <= cbbc_pkg::ERR_NONE;
      err_char  <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      lex      <= lex_next;
      count    <= count_next;
      top      <= top_next;
      bottom   <= bottom_next;
      err      <= err_next;
      err_char <= err_char_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res_status;
      reported_char <= res_char;
      nesting_depth <= 9'(count_next);
      lexer_state   <= cbbc_pkg::lex_code(lex_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("stack count beyond depth");

  a_err_freeze: assert property (@(posedge clk) disable iff (rst)
    (accept && !end_of_input && err != cbbc_pkg::ERR_NONE) |=>
      ($stable(count) && $stable(lex) && $stable(err)))
    else $error("state moved while error held");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (top == cbbc_pkg::BR_PAREN))
    else $error("top code not cleared on empty stack");

  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_input) |=>
      (count == '0 && err == cbbc_pkg::ERR_NONE && lex == cbbc_pkg::LX_NORMAL))
    else $error("end of input did not reinitialize");
`endif

endmodule

// ===== dv/c_bracket_balance_checker_tb.sv =====
// Self-checking testbench for c_bracket_balance_checker: directed table, then random C-like text.
module c_bracket_balance_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbbc_pkg::*;

  typedef logic [7:0] byte_t;

  typedef struct {
    status_t   st;
    byte_t     rc;
    logic [8:0] dep;
    lex_code_t lx;
  } report_t;

  typedef struct {
    byte_t   ch;
    logic    eoi;
    int      reps;
    bit      typed;
    report_t want;
  } row_t;

  localparam int DEPTH = STACK_DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int N_ROWS = 37;

  localparam byte_t OPEN_CH [3] = '{CH_LPAREN, CH_LSQUARE, CH_LCURLY};
  localparam byte_t CLOSE_CH [3] = '{CH_RPAREN, CH_RSQUARE, CH_RCURLY};
  localparam report_t NO_REPORT = '{ST_OK, 8'h00, 9'd0, LC_NORMAL};

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  byte_t      char_code;
  logic       end_of_input;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] status;
  byte_t      reported_char;
  logic [8:0] nesting_depth;
  logic [3:0] lexer_state;

  c_bracket_balance_checker #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .reported_char(reported_char),
    .nesting_depth(nesting_depth),
    .lexer_state  (lexer_state)
  );

  // Shadow of the checker state
  lex_code_t lex_now;
  brk_t      stk [DEPTH];
  int        depth_now;
  brk_t      top_now;
  brk_t      bottom_now;
  err_t      err_now;
  byte_t     err_char_now;

  report_t pending_reports [$];
  int      mismatches;
  int      cycles;
  bit      send_calm;

  row_t directed_rows [N_ROWS] = '{
    '{8'h00,        1'b1, 1,   1'b1, '{ST_BALANCED, 8'h00,      9'd0,   LC_NORMAL}},
    '{CH_RPAREN,    1'b0, 1,   1'b1, '{ST_UNEXP,    CH_RPAREN,  9'd0,   LC_NORMAL}},
    '{8'hff,        1'b0, 1,   1'b1, '{ST_UNEXP,    CH_RPAREN,  9'd0,   LC_NORMAL}},
    '{8'h00,        1'b1, 1,   1'b1, '{ST_UNEXP,    CH_RPAREN,  9'd0,   LC_NORMAL}},
    '{CH_LPAREN,    1'b0, 1,   1'b1, '{ST_OK,       8'h00,      9'd1,   LC_NORMAL}},
    '{CH_LSQUARE,   1'b0, 1,   1'b1, '{ST_OK,       8'h00,      9'd2,   LC_NORMAL}},
    '{CH_LCURLY,    1'b0, 1,   1'b1, '{ST_OK,       8'h00,      9'd3,   LC_NORMAL}},
    '{CH_RCURLY,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_DQUOTE,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_BACKSLASH, 1'b0, 1,   1'b0, NO_REPORT},
    '{CH_DQUOTE,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_RSQUARE,   1'b0, 1,   1'b0, NO_REPORT},
    '{CH_DQUOTE,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_SQUOTE,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_BACKSLASH, 1'b0, 1,   1'b0, NO_REPORT},
    '{CH_SQUOTE,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_SQUOTE,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_SLASH,     1'b0, 1,   1'b0, NO_REPORT},
    '{CH_STAR,      1'b0, 1,   1'b0, NO_REPORT},
    '{CH_RPAREN,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_STAR,      1'b0, 2,   1'b0, NO_REPORT},
    '{CH_SLASH,     1'b0, 1,   1'b0, NO_REPORT},
    '{CH_SLASH,     1'b0, 2,   1'b0, NO_REPORT},
    '{CH_LCURLY,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_NEWLINE,   1'b0, 1,   1'b0, NO_REPORT},
    '{CH_SLASH,     1'b0, 1,   1'b0, NO_REPORT},
    '{CH_LSQUARE,   1'b0, 1,   1'b0, NO_REPORT},
    '{8'h00,        1'b1, 1,   1'b1, '{ST_UNBAL,    CH_LPAREN,  9'd0,   LC_NORMAL}},
    '{CH_LPAREN,    1'b0, 1,   1'b0, NO_REPORT},
    '{CH_RSQUARE,   1'b0, 1,   1'b1, '{ST_UNEXP,    CH_RSQUARE, 9'd1,   LC_NORMAL}},
    '{8'hff,        1'b1, 1,   1'b1, '{ST_UNEXP,    CH_RSQUARE, 9'd0,   LC_NORMAL}},
    '{CH_LCURLY,    1'b0, 256, 1'b0, NO_REPORT},
    '{CH_LSQUARE,   1'b0, 1,   1'b1, '{ST_OVERFLOW, CH_LSQUARE, 9'd256, LC_NORMAL}},
    '{8'h00,        1'b1, 1,   1'b1, '{ST_OVERFLOW, CH_LSQUARE, 9'd0,   LC_NORMAL}},
    '{CH_SLASH,     1'b0, 1,   1'b0, NO_REPORT},
    '{CH_STAR,      1'b0, 1,   1'b0, NO_REPORT},
    '{8'h00,        1'b1, 1,   1'b1, '{ST_BALANCED, 8'h00,      9'd0,   LC_NORMAL}}
  };

  function automatic brk_t as_open(byte_t c);
    for (int i = 0; i < 3; i++)
      if (c == OPEN_CH[i]) return brk_t'(i);
    return BR_NONE;
  endfunction

  function automatic brk_t as_close(byte_t c);
    for (int i = 0; i < 3; i++)
      if (c == CLOSE_CH[i]) return brk_t'(i);
    return BR_NONE;
  endfunction

  function automatic lex_code_t enter_text(byte_t c);
    if (c == CH_SQUOTE) return LC_SQUOTE;
    if (c == CH_DQUOTE) return LC_DQUOTE;
    if (c == CH_SLASH) return LC_SLASH;
    return LC_NORMAL;
  endfunction

  function automatic lex_code_t lex_after(lex_code_t s, byte_t c);
    case (s)
      LC_SQUOTE: begin
        if (c == CH_SQUOTE) return LC_NORMAL;
        if (c == CH_BACKSLASH) return LC_SQ_ESC;
        return LC_SQUOTE;
      end
      LC_DQUOTE: begin
        if (c == CH_DQUOTE) return LC_NORMAL;
        if (c == CH_BACKSLASH) return LC_DQ_ESC;
        return LC_DQUOTE;
      end
      LC_SQ_ESC: return LC_SQUOTE;
      LC_DQ_ESC: return LC_DQUOTE;
      LC_LINE: begin
        if (c == CH_NEWLINE) return LC_NORMAL;
        return LC_LINE;
      end
      LC_BLOCK: begin
        if (c == CH_STAR) return LC_STAR;
        return LC_BLOCK;
      end
      LC_SLASH: begin
        if (c == CH_STAR) return LC_BLOCK;
        if (c == CH_SLASH) return LC_LINE;
        return enter_text(c);
      end
      LC_STAR: begin
        if (c == CH_SLASH) return LC_NORMAL;
        if (c == CH_STAR) return LC_STAR;
        return LC_BLOCK;
      end
      default: return enter_text(c);
    endcase
  endfunction

  function void clear_checker();
    lex_now      = LC_NORMAL;
    depth_now    = 0;
    top_now      = BR_PAREN;
    bottom_now   = BR_PAREN;
    err_now      = ERR_NONE;
    err_char_now = 8'h00;
  endfunction

  function report_t check_byte(byte_t c, logic eoi);
    report_t r;
    brk_t    o;
    brk_t    k;
    r.st = ST_OK;
    r.rc = 8'h00;
    if (eoi) begin
      if (err_now != ERR_NONE) begin
        r.st = status_t'({1'b0, err_now});
        r.rc = err_char_now;
      end else if (depth_now == 0) begin
        r.st = ST_BALANCED;
      end else begin
        r.st = ST_UNBAL;
        r.rc = OPEN_CH[bottom_now];
      end
      clear_checker();
    end else if (err_now == ERR_NONE) begin
      lex_now = lex_after(lex_now, c);
      if (lex_now == LC_NORMAL) begin
        o = as_open(c);
        k = as_close(c);
        if (o != BR_NONE) begin
          if (depth_now >= DEPTH) begin
            err_now      = ERR_OVERFLOW;
            err_char_now = c;
          end else begin
            if (depth_now == 0) bottom_now = o;
            stk[depth_now] = o;
            depth_now++;
            top_now = o;
          end
        end else if (k != BR_NONE) begin
          if (depth_now == 0 || top_now != k) begin
            err_now      = ERR_UNEXP;
            err_char_now = c;
          end else begin
            depth_now--;
            top_now = (depth_now > 0) ? stk[depth_now - 1] : BR_PAREN;
          end
        end
      end
    end
    if (!eoi && err_now != ERR_NONE) begin
      r.st = status_t'({1'b0, err_now});
      r.rc = err_char_now;
    end
    r.dep = depth_now[8:0];
    r.lx  = lex_now;
    return r;
  endfunction

  // Bias toward well-formed C text so the lexer and stack see deep behavior
  function automatic byte_t pick_char(int cap);
    int    r;
    byte_t letter;
    byte_t any_bracket;
    r = $urandom_range(0, 99);
    letter = byte_t'($urandom_range(8'h20, 8'h7e));
    any_bracket = $urandom_range(0, 1) ? OPEN_CH[$urandom_range(0, 2)]
                                       : CLOSE_CH[$urandom_range(0, 2)];
    if (r < 3) return byte_t'($urandom_range(0, 255));
    case (lex_now)
      LC_SQUOTE, LC_DQUOTE: begin
        if (r < 15) return CH_BACKSLASH;
        if (r < 40) return (lex_now == LC_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        if (r < 55) return any_bracket;
        return letter;
      end
      LC_SQ_ESC, LC_DQ_ESC: begin
        if (r < 30) return CH_BACKSLASH;
        if (r < 55) return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        return letter;
      end
      LC_LINE: begin
        if (r < 20) return CH_NEWLINE;
        if (r < 45) return any_bracket;
        return letter;
      end
      LC_BLOCK, LC_STAR: begin
        if (r < 30) return CH_STAR;
        if (r < 50) return CH_SLASH;
        if (r < 65) return any_bracket;
        return letter;
      end
      default: begin
        if (r < 33)
          return (depth_now < cap) ? OPEN_CH[$urandom_range(0, 2)] : CLOSE_CH[top_now];
        if (r < 58)
          return (depth_now > 0) ? CLOSE_CH[top_now] : OPEN_CH[$urandom_range(0, 2)];
        if (r < 61) return CLOSE_CH[$urandom_range(0, 2)];
        if (r < 66) return CH_SQUOTE;
        if (r < 71) return CH_DQUOTE;
        if (r < 79) return CH_SLASH;
        if (r < 83) return CH_STAR;
        if (r < 87) return CH_NEWLINE;
        if (r < 89) return CH_BACKSLASH;
        return letter;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_item(byte_t c, logic eoi, bit typed, report_t want);
    int      gap;
    report_t got;
    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    got = check_byte(c, eoi);
    pending_reports.push_back(typed ? want : got);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result checker and output stall
  initial begin
    int      hold_left;
    int      run_left;
    int      results;
    int      r;
    bit      rx_calm;
    report_t want;
    hold_left = 0;
    run_left  = 0;
    results   = 0;
    rx_calm   = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: status %0d char %02h depth %0d lexer %0d",
                     status, reported_char, nesting_depth, lexer_state);
        end else begin
          want = pending_reports.pop_front();
          if (status !== want.st || reported_char !== want.rc ||
              nesting_depth !== want.dep || lexer_state !== want.lx) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch %0d: want %0d %02h %0d %0d, got %0d %02h %0d %0d",
                       results, want.st, want.rc, want.dep, want.lx,
                       status, reported_char, nesting_depth, lexer_state);
          end
        end
        // hold off long enough to back up the input
        if (results == 150 || results == 450) hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 79) == 0) rx_calm = !rx_calm;
        r = $urandom_range(0, 99);
        if (rx_calm || r < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          run_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(6, 24);
        end
      end
    end
  end

  initial begin
    int    done_items;
    int    seq_len;
    int    seq_pos;
    int    cap;
    bit    close_out;
    bit    paused;
    logic  eoi;
    byte_t c;
    rst          = 1'b1;
    in_valid     = 1'b0;
    char_code    = 8'h00;
    end_of_input = 1'b0;
    mismatches   = 0;
    send_calm    = 1'b0;
    clear_checker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++)
      for (int j = 0; j < directed_rows[i].reps; j++)
        send_item(directed_rows[i].ch, directed_rows[i].eoi,
                  directed_rows[i].typed && directed_rows[i].reps == 1,
                  directed_rows[i].want);
    wait_drained();

    done_items = 0;
    paused     = 1'b0;
    seq_pos    = 0;
    seq_len    = $urandom_range(4, 50);
    cap        = $urandom_range(2, 16);
    close_out  = 1'b1;
    while (done_items < RANDOM_ITEMS) begin
      eoi = 1'b0;
      c = pick_char(cap);
      if (err_now != ERR_NONE) begin
        eoi = ($urandom_range(0, 3) == 0);
      end else if (seq_pos >= seq_len) begin
        if (close_out && depth_now > 0 && lex_now == LC_NORMAL) c = CLOSE_CH[top_now];
        else eoi = 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        eoi = 1'b1;
      end
      if (eoi) c = byte_t'($urandom_range(0, 255));
      if (err_now == ERR_NONE || eoi) done_items++;
      send_item(c, eoi, 1'b0, NO_REPORT);
      seq_pos++;
      if (eoi) begin
        seq_pos   = 0;
        close_out = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 14) == 0) begin
          seq_len = $urandom_range(150, 400);
          cap     = DEPTH + 4;
        end else begin
          seq_len = $urandom_range(4, 50);
          cap     = $urandom_range(2, 16);
        end
      end
      if (!paused && done_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
